FILE: hdl/keypad_matrix_port_with_ghosting_core_assert.svh
// Assertion macros for the keypad matrix port checker.
// No dependencies; included by the checker file.
`ifndef KEYPAD_MATRIX_PORT_WITH_GHOSTING_CORE_ASSERT_SVH
`define KEYPAD_MATRIX_PORT_WITH_GHOSTING_CORE_ASSERT_SVH

// same-cycle implication, off during reset
`define KMP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("kmp assertion failed");

// next-cycle implication, off during reset
`define KMP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("kmp assertion failed");

// next-cycle implication, always active
`define KMP_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("kmp assertion failed");

`endif

FILE: hdl/kmp_pkg.sv
// Shared types and constants for the keypad matrix port.
// No dependencies.
package kmp_pkg;

   localparam int ROW_W = 8;
   localparam int GRP_W = 3;
   localparam int BIT_W = 3;

   typedef enum logic [1:0] {
      CMD_WRITE   = 2'd0,
      CMD_READ    = 2'd1,
      CMD_PRESS   = 2'd2,
      CMD_RELEASE = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type            command;
      logic [ROW_W-1:0]   bus_data;
      logic [GRP_W-1:0]   key_group;
      logic [BIT_W-1:0]   key_bit;
      logic               is_on_key;
   } req_type;

endpackage

FILE: hdl/keypad_matrix_port_with_ghosting_core.sv
// Keypad matrix port with single-level ghosting.
// A request is held in the input register, and its result then in the result register.
// Throughput: one request per cycle while results are taken; the input and result
// registers let a new request enter while a result waits to be taken.
// Reset (synchronous): releases all keys, clears select mask, on-key flag, valids.
// Depends on kmp_pkg, kmp_regs and kmp_ghost.
module keypad_matrix_port_with_ghosting_core import kmp_pkg::*; #(
   parameter int NUM_GROUPS = 7
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_command,
   input  logic [ROW_W-1:0] req_bus_data,
   input  logic [GRP_W-1:0] req_key_group,
   input  logic [BIT_W-1:0] req_key_bit,
   input  logic             req_is_on_key,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [ROW_W-1:0] rsp_read_data,
   output logic             rsp_on_state
);

   req_type                          req_ff;
   req_type                          req_in;
   logic                             stage_valid_ff;
   logic                             stage_valid_in;
   logic                             stage_fire;
   logic                             rsp_valid_ff;
   logic                             rsp_valid_in;
   logic [ROW_W-1:0]                 read_ff;
   logic [ROW_W-1:0]                 read_in;
   logic                             on_ff;
   logic                             on_in;
   logic [NUM_GROUPS-1:0][ROW_W-1:0] matrix;
   logic [ROW_W-1:0]                 select_mask;
   logic [ROW_W-1:0]                 port_data;
   logic                             req_take;

   assign req_in = '{
      command:   cmd_type'(req_command),
      bus_data:  req_bus_data,
      key_group: req_key_group,
      key_bit:   req_key_bit,
      is_on_key: req_is_on_key
   };

   assign stage_fire     = stage_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready      = !stage_valid_ff || stage_fire;
   assign req_take       = req_valid && req_ready;
   assign stage_valid_in = req_take || (stage_valid_ff && !stage_fire);
   assign rsp_valid_in   = stage_fire || (rsp_valid_ff && !rsp_ready);
   assign read_in        = (req_ff.command == CMD_READ) ? port_data : '0;

   kmp_regs #(.NUM_GROUPS(NUM_GROUPS)) u_regs (
      .clock       (clock),
      .reset       (reset),
      .upd_en      (stage_fire),
      .req         (req_ff),
      .matrix      (matrix),
      .select_mask (select_mask),
      .on_in       (on_in)
   );

   kmp_ghost #(.NUM_GROUPS(NUM_GROUPS)) u_ghost (
      .matrix      (matrix),
      .select_mask (select_mask),
      .port_data   (port_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      if (req_take) begin
         req_ff <= req_in;
      end
      if (stage_fire) begin
         read_ff <= read_in;
         on_ff   <= on_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = read_ff;
   assign rsp_on_state  = on_ff;

endmodule

FILE: hdl/kmp_regs.sv
// Key matrix, group-select mask and on-key flag, with their update logic.
// Depends on kmp_pkg.
module kmp_regs import kmp_pkg::*; #(
   parameter int NUM_GROUPS = 7
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             upd_en,
   input  req_type                          req,
   output logic [NUM_GROUPS-1:0][ROW_W-1:0] matrix,
   output logic [ROW_W-1:0]                 select_mask,
   output logic                             on_in
);

   logic [NUM_GROUPS-1:0][ROW_W-1:0] matrix_ff;
   logic [NUM_GROUPS-1:0][ROW_W-1:0] matrix_in;
   logic [ROW_W-1:0]                 mask_ff;
   logic [ROW_W-1:0]                 mask_in;
   logic                             on_ff;
   logic                             is_key_cmd;
   logic                             is_press;
   logic [ROW_W-1:0]                 bit_sel;

   assign is_key_cmd = (req.command == CMD_PRESS) || (req.command == CMD_RELEASE);
   assign is_press   = (req.command == CMD_PRESS);
   assign bit_sel    = ROW_W'(1) << req.key_bit;

   assign mask_in = (upd_en && (req.command == CMD_WRITE)) ? ~req.bus_data : mask_ff;
   assign on_in   = (upd_en && is_key_cmd && req.is_on_key) ? is_press : on_ff;

   for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_row
      logic hit;
      assign hit = upd_en && is_key_cmd && !req.is_on_key && (req.key_group == GRP_W'(g));
      assign matrix_in[g] = !hit     ? matrix_ff[g] :
                            is_press ? (matrix_ff[g] | bit_sel) :
                                       (matrix_ff[g] & ~bit_sel);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         matrix_ff <= '0;
         mask_ff   <= '0;
         on_ff     <= 1'b0;
      end else begin
         matrix_ff <= matrix_in;
         mask_ff   <= mask_in;
         on_ff     <= on_in;
      end
   end

   assign matrix      = matrix_ff;
   assign select_mask = mask_ff;

endmodule

FILE: hdl/kmp_ghost.sv
// Ghosting network: ORs the selected rows, each widened by rows sharing a key, and inverts.
// Depends on kmp_pkg.
module kmp_ghost import kmp_pkg::*; #(
   parameter int NUM_GROUPS = 7
) (
   input  logic [NUM_GROUPS-1:0][ROW_W-1:0] matrix,
   input  logic [ROW_W-1:0]                 select_mask,
   output logic [ROW_W-1:0]                 port_data
);

   logic [NUM_GROUPS-1:0][ROW_W-1:0] ghost;
   logic [ROW_W-1:0]                 acc;

   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         ghost[g] = '0;
         for (int i = 0; i < NUM_GROUPS; i++) begin
            if ((matrix[g] & matrix[i]) != '0) begin
               ghost[g] = ghost[g] | matrix[g] | matrix[i];
            end
         end
      end
   end

   always_comb begin
      acc = '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         if (select_mask[g]) begin
            acc = acc | ghost[g];
         end
      end
   end

   assign port_data = ~acc;

endmodule

FILE: hdl/kmp_checker.sv
// Port-level checks for the keypad matrix port, bound to the top level.
// Depends on kmp_pkg and the assertion macro header.
`include "keypad_matrix_port_with_ghosting_core_assert.svh"

module kmp_checker import kmp_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [ROW_W-1:0] rsp_read_data,
   input logic             rsp_on_state
);

   // results are held while the consumer stalls
   `KMP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_read_data) && $stable(rsp_on_state) && rsp_valid)

   // the input side stalls only behind a blocked result
   `KMP_ASSERT_IMPLY(a_stall_cause, clock, reset, !req_ready, rsp_valid && !rsp_ready)

   // reset drops any pending result
   `KMP_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid && req_ready)

endmodule

bind keypad_matrix_port_with_ghosting_core kmp_checker u_kmp_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_read_data (rsp_read_data),
   .rsp_on_state  (rsp_on_state)
);
